### rtl/satlc_pkg.sv
// satlc_pkg: request codes, state encoding and status struct for the translation lookup cache
// no dependencies
package satlc_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_LOOKUP    = 3'd0;
  localparam req_t REQ_INSERT    = 3'd1;
  localparam req_t REQ_INV_GUEST = 3'd2;
  localparam req_t REQ_INV_HOST  = 3'd3;
  localparam req_t REQ_INV_ALL   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ACCESS = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_CLEAR  = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  typedef struct packed {
    logic hit;
    logic data_we;
  } upd_stat_t;

endpackage

### rtl/satlc_ifs.sv
// satlc_ifs: valid/ready channels for request and response words
// depends on satlc_pkg
interface satlc_req_if;
  logic                   valid;
  logic                   ready;
  satlc_pkg::req_t        req_type;
  logic [31:0]            guest_addr;
  logic [31:0]            host_addr;

  modport source (output valid, output req_type, output guest_addr, output host_addr,
                  input ready);
  modport sink (input valid, input req_type, input guest_addr, input host_addr,
                output ready);
endinterface

interface satlc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] found_host_addr;

  modport source (output valid, output hit, output found_host_addr, input ready);
  modport sink (input valid, input hit, input found_host_addr, output ready);
endinterface

### rtl/set_assoc_translation_lookup_cache_core.sv
// set_assoc_translation_lookup_cache_core: top level of the translation lookup cache
// depends on satlc_pkg, satlc_ifs, satlc_ram, satlc_set_upd
//
// Maps guest code addresses to host entry handles, NUM_WAYS ways per set, nru replacement.
// req (sink): one word per request: req_type, guest_addr, host_addr.
// rsp (source): one word per request, in order: hit, found_host_addr.
// Set rows live in two rams: tags and handles, and valid plus nru bits, both indexed by
// (guest_addr >> 2) mod NUM_SETS (NUM_SETS a power of two).
// Lookup, insert and guest invalidate: one ram read issued at the accept edge and one
// write-back once the output register is free, which also loads the response. Host
// invalidate walks every set. Invalidate all rewrites the valid/nru ram one set a cycle.
// One request is in flight at a time; a new one is taken while the previous response
// still waits in the output register.
// Reset: a clearing pass over every set of the valid/nru ram runs first, with
// req.ready low. If the receiver stalls, the finishing request holds until the output
// register frees, and no further request is taken meanwhile.
module set_assoc_translation_lookup_cache_core #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 4
) (
  input  logic              clk,
  input  logic              rst,
  satlc_req_if.sink         req,
  satlc_rsp_if.source       rsp
);

  localparam int unsigned SET_BITS = $clog2(NUM_SETS);
  localparam int unsigned META_W   = 2 * NUM_WAYS;
  localparam int unsigned DATA_W   = NUM_WAYS * 64;
  localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NUM_SETS - 1);

  satlc_pkg::state_t    state;
  satlc_pkg::req_t      op_reg;
  logic [31:0]          guest_reg;
  logic [31:0]          host_reg;
  logic [SET_BITS-1:0]  idx;
  logic [SET_BITS-1:0]  p_idx;
  logic                 p_vld;
  logic                 rd_done;
  logic                 clr_rst;

  logic                 accept;
  logic                 adv;
  logic                 load;
  logic                 rd_en;
  logic [SET_BITS-1:0]  rd_addr;
  logic [SET_BITS-1:0]  set_reg;
  logic [META_W-1:0]    meta_rd;
  logic [DATA_W-1:0]    data_rd;
  logic                 meta_we;
  logic [SET_BITS-1:0]  meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic                 data_we;

  satlc_pkg::req_t      upd_op;
  logic [DATA_W-1:0]    data_next;
  logic [NUM_WAYS-1:0]  valid_next;
  logic [NUM_WAYS-1:0]  nru_next;
  satlc_pkg::upd_stat_t stat;
  logic [31:0]          found;

  assign req.ready = (state == satlc_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign adv       = !rsp.valid || rsp.ready;
  assign load      = adv && ((state == satlc_pkg::ST_ACCESS) || (state == satlc_pkg::ST_RESP));
  assign set_reg   = guest_reg[2 +: SET_BITS];

  always_comb begin
    rd_addr = idx;
    rd_en   = 1'b0;
    case (state)
      satlc_pkg::ST_IDLE: begin
        rd_addr = req.guest_addr[2 +: SET_BITS];
        rd_en   = req.valid;
      end
      satlc_pkg::ST_SCAN: begin
        rd_en = !rd_done;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign upd_op = (state == satlc_pkg::ST_SCAN) ? satlc_pkg::REQ_INV_HOST : op_reg;

  satlc_set_upd #(
    .NUM_WAYS(NUM_WAYS)
  ) u_upd (
    .op         (upd_op),
    .guest_addr (guest_reg),
    .host_addr  (host_reg),
    .data       (data_rd),
    .valid      (meta_rd[NUM_WAYS-1:0]),
    .nru        (meta_rd[META_W-1:NUM_WAYS]),
    .data_next  (data_next),
    .valid_next (valid_next),
    .nru_next   (nru_next),
    .stat       (stat),
    .found      (found)
  );

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_reg;
    meta_wdata = {nru_next, valid_next};
    case (state)
      satlc_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = idx;
        meta_wdata = {{NUM_WAYS{1'b1}}, {NUM_WAYS{1'b0}}};
      end
      satlc_pkg::ST_SCAN: begin
        meta_we    = p_vld;
        meta_waddr = p_idx;
      end
      satlc_pkg::ST_ACCESS: begin
        meta_we = adv;
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  assign data_we = (state == satlc_pkg::ST_ACCESS) && adv && stat.data_we;

  satlc_ram #(
    .WIDTH(META_W),
    .DEPTH(NUM_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rd)
  );

  satlc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_SETS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (set_reg),
    .wdata (data_next),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= satlc_pkg::ST_CLEAR;
      idx     <= '0;
      p_vld   <= 1'b0;
      rd_done <= 1'b0;
      clr_rst <= 1'b1;
    end else begin
      case (state)
        satlc_pkg::ST_IDLE: begin
          if (accept) begin
            idx     <= '0;
            p_vld   <= 1'b0;
            rd_done <= 1'b0;
            clr_rst <= 1'b0;
            if (req.req_type == satlc_pkg::REQ_INV_HOST) begin
              state <= satlc_pkg::ST_SCAN;
            end else if (req.req_type == satlc_pkg::REQ_INV_ALL) begin
              state <= satlc_pkg::ST_CLEAR;
            end else begin
              state <= satlc_pkg::ST_ACCESS;
            end
          end
        end
        satlc_pkg::ST_ACCESS: begin
          if (adv) begin
            state <= satlc_pkg::ST_IDLE;
          end
        end
        satlc_pkg::ST_SCAN: begin
          p_vld <= !rd_done;
          p_idx <= idx;
          if (!rd_done) begin
            if (idx == LAST_SET) begin
              rd_done <= 1'b1;
            end else begin
              idx <= idx + SET_BITS'(1);
            end
          end
          if (p_vld && (p_idx == LAST_SET)) begin
            state <= satlc_pkg::ST_RESP;
          end
        end
        satlc_pkg::ST_CLEAR: begin
          idx <= idx + SET_BITS'(1);
          if (idx == LAST_SET) begin
            state <= clr_rst ? satlc_pkg::ST_IDLE : satlc_pkg::ST_RESP;
          end
        end
        satlc_pkg::ST_RESP: begin
          if (adv) begin
            state <= satlc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= satlc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg    <= req.req_type;
      guest_reg <= req.guest_addr;
      host_reg  <= req.host_addr;
    end
  end

  // response word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.hit             <= (state == satlc_pkg::ST_ACCESS) && stat.hit;
      rsp.found_host_addr <= (state == satlc_pkg::ST_ACCESS) ? found : 32'd0;
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == satlc_pkg::ST_ACCESS) || (state == satlc_pkg::ST_SCAN) ||
               (state == satlc_pkg::ST_CLEAR))
    else $error("request accepted but no work started");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == satlc_pkg::ST_ACCESS) ||
                         $past(state == satlc_pkg::ST_RESP))
    else $error("response loaded outside a finishing step");

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == satlc_pkg::ST_SCAN) && p_vld && !rd_done |-> idx != p_idx)
    else $error("scan reads the set it is writing back");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == satlc_pkg::ST_IDLE) |-> !meta_we && !data_we)
    else $error("ram written while idle");

endmodule

### rtl/satlc_ram.sv
// satlc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module satlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/satlc_set_upd.sv
// satlc_set_upd: tag/handle compare and nru update for one set row
// depends on satlc_pkg
module satlc_set_upd #(
  parameter int unsigned NUM_WAYS = 4
) (
  input  satlc_pkg::req_t         op,
  input  logic [31:0]             guest_addr,
  input  logic [31:0]             host_addr,
  input  logic [NUM_WAYS*64-1:0]  data,
  input  logic [NUM_WAYS-1:0]     valid,
  input  logic [NUM_WAYS-1:0]     nru,
  output logic [NUM_WAYS*64-1:0]  data_next,
  output logic [NUM_WAYS-1:0]     valid_next,
  output logic [NUM_WAYS-1:0]     nru_next,
  output satlc_pkg::upd_stat_t    stat,
  output logic [31:0]             found
);

  logic [NUM_WAYS-1:0] tmatch;
  logic [NUM_WAYS-1:0] hmatch;
  logic [NUM_WAYS-1:0] hit_oh;
  logic [NUM_WAYS-1:0] free_oh;
  logic [NUM_WAYS-1:0] ins_oh;
  logic [NUM_WAYS-1:0] touch_oh;
  logic [NUM_WAYS-1:0] tch_cur;
  logic [NUM_WAYS-1:0] touched;
  logic [31:0]         hit_handle;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      tmatch[w] = valid[w] && (data[w*64 +: 32] == guest_addr);
      hmatch[w] = valid[w] && (data[w*64+32 +: 32] == host_addr);
    end
  end

  // lowest set bit isolation
  assign hit_oh  = tmatch & (~tmatch + NUM_WAYS'(1));
  assign free_oh = nru & (~nru + NUM_WAYS'(1));
  assign ins_oh  = (nru == '0) ? NUM_WAYS'(1) : free_oh;

  assign touch_oh = (op == satlc_pkg::REQ_INSERT) ? ins_oh : hit_oh;
  assign tch_cur  = nru & ~touch_oh;
  assign touched  = (tch_cur == '0) ? ~touch_oh : tch_cur;

  always_comb begin
    hit_handle = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit_handle = hit_handle | (data[w*64+32 +: 32] & {32{hit_oh[w]}});
    end
  end

  always_comb begin
    data_next  = data;
    valid_next = valid;
    nru_next   = nru;
    stat       = '0;
    found      = '0;
    case (op)
      satlc_pkg::REQ_LOOKUP: begin
        stat.hit = |tmatch;
        found    = hit_handle;
        if (|tmatch) begin
          nru_next = touched;
        end
      end
      satlc_pkg::REQ_INSERT: begin
        stat.data_we = 1'b1;
        nru_next     = touched;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (ins_oh[w]) begin
            data_next[w*64 +: 32]    = guest_addr;
            data_next[w*64+32 +: 32] = host_addr;
            valid_next[w]            = 1'b1;
          end
        end
      end
      satlc_pkg::REQ_INV_GUEST: begin
        valid_next = valid & ~tmatch;
        nru_next   = nru | tmatch;
      end
      satlc_pkg::REQ_INV_HOST: begin
        valid_next = valid & ~hmatch;
        nru_next   = nru | hmatch;
      end
      default: begin
        stat = '0;
      end
    endcase
  end

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for set_assoc_translation_lookup_cache_core
// depends on satlc_pkg, satlc_ifs and the core; keeps its own copy of the cache and nru bits
// directed cases first, then random requests over small address and handle pools
module tb_top;

  localparam int unsigned NUM_SETS = 64;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned NUM_ENTRIES = NUM_SETS * NUM_WAYS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;
  localparam satlc_pkg::req_t REQ_RESERVED_FIRST = 3'd5;
  localparam satlc_pkg::req_t REQ_RESERVED_LAST = 3'd7;

  typedef struct packed {
    logic        hit;
    logic [31:0] handle;
  } lookup_result_t;

  logic clk;
  logic rst;

  satlc_req_if req_bus ();
  satlc_rsp_if rsp_bus ();

  set_assoc_translation_lookup_cache_core #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  logic [31:0]         tag_mem    [NUM_ENTRIES];
  logic [31:0]         handle_mem [NUM_ENTRIES];
  logic                valid_mem  [NUM_ENTRIES];
  logic [NUM_WAYS-1:0] nru_mem    [NUM_SETS];

  lookup_result_t owed_replies[$];
  int             error_count = 0;
  int             cycle_count = 0;
  bit             steady = 1'b0;
  logic [31:0]    guest_pool [32];
  logic [31:0]    handle_pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int set_of(logic [31:0] guest);
    return int'((guest >> 2) % NUM_SETS);
  endfunction

  function automatic void flush_model();
    for (int i = 0; i < NUM_ENTRIES; i++) valid_mem[i] = 1'b0;
    for (int s = 0; s < NUM_SETS; s++) nru_mem[s] = '1;
  endfunction

  function automatic void mark_recent(int s, int w);
    logic [NUM_WAYS-1:0] way_bit;
    logic [NUM_WAYS-1:0] left;
    way_bit = '0;
    way_bit[w] = 1'b1;
    left = nru_mem[s] & ~way_bit;
    if (left == '0) left = ~way_bit;
    nru_mem[s] = left;
  endfunction

  // applies one request to the local copy and returns the reply it should give
  function automatic lookup_result_t translate_and_update(satlc_pkg::req_t kind,
                                                          logic [31:0] guest,
                                                          logic [31:0] host);
    lookup_result_t r;
    int s;
    int base;
    int victim;
    r = '0;
    s = set_of(guest);
    base = s * NUM_WAYS;
    case (kind)
      satlc_pkg::REQ_LOOKUP: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!r.hit && valid_mem[base + w] && tag_mem[base + w] == guest) begin
            r.hit = 1'b1;
            r.handle = handle_mem[base + w];
            mark_recent(s, w);
          end
        end
      end
      satlc_pkg::REQ_INSERT: begin
        victim = -1;
        for (int w = 0; w < NUM_WAYS; w++)
          if (victim < 0 && nru_mem[s][w]) victim = w;
        if (victim < 0) victim = 0;
        tag_mem[base + victim] = guest;
        handle_mem[base + victim] = host;
        valid_mem[base + victim] = 1'b1;
        mark_recent(s, victim);
      end
      satlc_pkg::REQ_INV_GUEST: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (valid_mem[base + w] && tag_mem[base + w] == guest) begin
            valid_mem[base + w] = 1'b0;
            nru_mem[s][w] = 1'b1;
          end
        end
      end
      satlc_pkg::REQ_INV_HOST: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (valid_mem[i] && handle_mem[i] == host) begin
            valid_mem[i] = 1'b0;
            nru_mem[i / NUM_WAYS][i % NUM_WAYS] = 1'b1;
          end
        end
      end
      satlc_pkg::REQ_INV_ALL: flush_model();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(input satlc_pkg::req_t kind, input logic [31:0] guest,
                          input logic [31:0] host);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.guest_addr <= guest;
    req_bus.host_addr <= host;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    owed_replies.push_back(translate_and_update(kind, guest, host));
  endtask

  task automatic test_boundaries();
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_req(satlc_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(satlc_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(satlc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_0100, 32'h0000_0000);
  endtask

  // five inserts into one set: the nru bits run out and the oldest way goes
  task automatic test_nru_eviction();
    for (int k = 0; k < 5; k++)
      send_req(satlc_pkg::REQ_INSERT, 32'h0000_0014 + k * 32'h1000, 32'hA000_0000 + k);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_0014, 32'h0);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_1014, 32'h0);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h0000_4014, 32'h0);
  endtask

  task automatic test_duplicate_tags();
    send_req(satlc_pkg::REQ_INSERT, 32'h5555_5524, 32'h1111_1111);
    send_req(satlc_pkg::REQ_INSERT, 32'h5555_5524, 32'h2222_2222);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h5555_5524, 32'h0);
    send_req(satlc_pkg::REQ_INV_GUEST, 32'h5555_5524, 32'h0);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h5555_5524, 32'h0);
  endtask

  task automatic test_host_scan();
    send_req(satlc_pkg::REQ_INSERT, 32'h8000_0040, 32'h0BAD_F00D);
    send_req(satlc_pkg::REQ_INSERT, 32'h4000_00F0, 32'h0BAD_F00D);
    send_req(satlc_pkg::REQ_INV_HOST, 32'h0000_0000, 32'h0BAD_F00D);
    send_req(satlc_pkg::REQ_LOOKUP, 32'h4000_00F0, 32'h0);
  endtask

  task automatic test_odd_codes();
    for (int c = REQ_RESERVED_FIRST; c <= REQ_RESERVED_LAST; c++)
      send_req(satlc_pkg::req_t'(c), $urandom(), $urandom());
    send_req(satlc_pkg::REQ_INV_ALL, $urandom(), $urandom());
    send_req(satlc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_random_traffic();
    int pick;
    satlc_pkg::req_t kind;
    logic [31:0] guest;
    logic [31:0] host;
    for (int i = 0; i < 32; i++) begin
      guest_pool[i] = $urandom();
      guest_pool[i][7:2] = 6'($urandom_range(0, 7));
    end
    for (int i = 0; i < 8; i++) handle_pool[i] = $urandom();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / 50) % 3) == 2;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = satlc_pkg::REQ_LOOKUP;
      else if (pick < 72) kind = satlc_pkg::REQ_INSERT;
      else if (pick < 82) kind = satlc_pkg::REQ_INV_GUEST;
      else if (pick < 91) kind = satlc_pkg::REQ_INV_HOST;
      else if (pick < 93) kind = satlc_pkg::REQ_INV_ALL;
      else if (pick < 96)
        kind = satlc_pkg::req_t'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
      else kind = satlc_pkg::REQ_LOOKUP;
      guest = ($urandom_range(0, 9) == 0) ? $urandom() : guest_pool[$urandom_range(0, 31)];
      host = ($urandom_range(0, 9) == 0) ? $urandom() : handle_pool[$urandom_range(0, 7)];
      send_req(kind, guest, host);
    end
    steady = 1'b0;
  endtask

  // response side back-pressure
  initial begin
    int stall;
    rsp_bus.ready <= 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected word, hit %0b handle %08h", $time, rsp_bus.hit,
                 rsp_bus.found_host_addr);
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        if (rsp_bus.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_bus.hit);
          error_count++;
        end
        if (rsp_bus.found_host_addr !== want.handle) begin
          $display("%0t: found_host_addr expected %08h actual %08h", $time, want.handle,
                   rsp_bus.found_host_addr);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still owed", $time, owed_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= satlc_pkg::REQ_LOOKUP;
    req_bus.guest_addr <= '0;
    req_bus.host_addr <= '0;
    flush_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_boundaries();
    test_nru_eviction();
    test_duplicate_tags();
    test_host_scan();
    test_odd_codes();
    test_random_traffic();
    req_bus.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (NUM_SETS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
